// ===== hw/rtl/gffr_pkg.sv =====
// shared types and constants of the grid first-fit rectangle allocator
// no dependencies; used by every other file of the block

package gffr_pkg;

    // field widths
    localparam int IMG_W   = 13;
    localparam int CELL_W  = 11;
    localparam int GRID_W  = 7;
    localparam int POS_W   = 6;
    localparam int OFS_W   = 16;

    // cell count divider: numerator is image size plus cell size less one
    localparam int NUM_W     = 14;
    localparam int DEN_W     = 11;
    localparam int DIV_STEPS = 14;
    localparam int STEP_W    = 4;

    // configuration register indexes
    localparam logic [1:0] REG_CELL_WIDTH  = 2'd0;
    localparam logic [1:0] REG_CELL_HEIGHT = 2'd1;
    localparam logic [1:0] REG_GRID_COLS   = 2'd2;
    localparam logic [1:0] REG_GRID_ROWS   = 2'd3;

    localparam logic [OFS_W-1:0] OFS_MAX = '1;

    typedef struct packed {
        logic [CELL_W-1:0] cell_width_px;
        logic [CELL_W-1:0] cell_height_px;
        logic [GRID_W-1:0] grid_cols;
        logic [GRID_W-1:0] grid_rows;
    } t_cfg;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV_W,
        ST_DIV_H,
        ST_CHECK,
        ST_ACC_RD,
        ST_ACC_OR,
        ST_SCAN,
        ST_MARK_RD,
        ST_MARK_WR,
        ST_FINISH
    } t_state;

    typedef struct packed {
        logic load;
        logic div_start;
        logic div_sel_h;
        logic take_nc;
        logic take_nr;
        logic row_start;
        logic next_row;
        logic rd_en;
        logic acc;
        logic scan_start;
        logic scan_step;
        logic mark_start;
        logic mark_wr;
        logic set_hit;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic div_done;
        logic too_big;
        logic i_last;
        logic scan_end;
        logic scan_hit;
        logic row_last;
        logic out_free;
    } t_sts;

endpackage

// ===== hw/rtl/gffr_if.sv =====
// request and result channel interfaces of the allocator
// depends on gffr_pkg for field widths

interface gffr_req_if;
    logic                        valid;
    logic                        ready;
    logic [gffr_pkg::IMG_W-1:0]  image_width;
    logic [gffr_pkg::IMG_W-1:0]  image_height;

    modport source (output valid, output image_width, output image_height, input ready);
    modport sink   (input valid, input image_width, input image_height, output ready);
endinterface

interface gffr_res_if;
    logic                        valid;
    logic                        ready;
    logic                        placed;
    logic [gffr_pkg::POS_W-1:0]  cell_col;
    logic [gffr_pkg::POS_W-1:0]  cell_row;
    logic [gffr_pkg::OFS_W-1:0]  x_offset;
    logic [gffr_pkg::OFS_W-1:0]  y_offset;

    modport source (output valid, output placed, output cell_col, output cell_row,
                    output x_offset, output y_offset, input ready);
    modport sink   (input valid, input placed, input cell_col, input cell_row,
                    input x_offset, input y_offset, output ready);
endinterface

// ===== hw/rtl/grid_first_fit_rect_allocator.sv =====
// top level of the grid first-fit rectangle allocator: config registers and wiring
// depends on gffr_pkg, gffr_if, gffr_ctrl and gffr_dp

// One request beat carries an image size in pixels; one result beat comes back
// for every request. Each size is rounded up to whole cells by a shared
// one-bit-per-cycle divider, then candidate rows are tried top to bottom: for
// each row the covered bitmap rows are ORed together from the occupancy memory
// (a read state then an OR state per covered row, one memory port) and the
// union is scanned one column per cycle for a free run. A hit rewrites the
// covered rows, each with a read state then a write state. One item is in
// flight at a time; the memory port and the column scan set the throughput.
// The bitmap is empty after reset with no clearing pass: each row has a valid
// bit that reset clears. Configuration registers (APB, byte address 4*index):
// cell_width_px, cell_height_px, grid_cols, grid_rows; write only while idle.

module grid_first_fit_rect_allocator #(
    parameter int MAX_COLS = 64,
    parameter int MAX_ROWS = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    gffr_req_if.sink    i_req,
    gffr_res_if.source  o_res,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    gffr_pkg::t_cfg r_cfg;
    gffr_pkg::t_cmd cmd;
    gffr_pkg::t_sts sts;
    logic           cfg_wr;

    // register write in the access phase
    assign cfg_wr = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.cell_width_px  <= gffr_pkg::CELL_W'(32);
            r_cfg.cell_height_px <= gffr_pkg::CELL_W'(32);
            r_cfg.grid_cols      <= gffr_pkg::GRID_W'(64);
            r_cfg.grid_rows      <= gffr_pkg::GRID_W'(64);
        end else if (cfg_wr) begin
            case (paddr[3:2])
                gffr_pkg::REG_CELL_WIDTH:  r_cfg.cell_width_px  <= pwdata[gffr_pkg::CELL_W-1:0];
                gffr_pkg::REG_CELL_HEIGHT: r_cfg.cell_height_px <= pwdata[gffr_pkg::CELL_W-1:0];
                gffr_pkg::REG_GRID_COLS:   r_cfg.grid_cols      <= pwdata[gffr_pkg::GRID_W-1:0];
                gffr_pkg::REG_GRID_ROWS:   r_cfg.grid_rows      <= pwdata[gffr_pkg::GRID_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // readback
    always_comb begin
        case (paddr[3:2])
            gffr_pkg::REG_CELL_WIDTH:  prdata = 32'(r_cfg.cell_width_px);
            gffr_pkg::REG_CELL_HEIGHT: prdata = 32'(r_cfg.cell_height_px);
            gffr_pkg::REG_GRID_COLS:   prdata = 32'(r_cfg.grid_cols);
            gffr_pkg::REG_GRID_ROWS:   prdata = 32'(r_cfg.grid_rows);
            default:                   prdata = '0;
        endcase
    end

    // sequencer
    gffr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (i_req.ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    // bitmap, divider, scan and result register
    gffr_dp #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_width  (i_req.image_width),
        .i_height (i_req.image_height),
        .i_cmd    (cmd),
        .o_sts    (sts),
        .res      (o_res)
    );

endmodule

// ===== hw/rtl/gffr_div.sv =====
// restoring divider, one quotient bit per cycle
// depends on gffr_pkg for widths and step count

module gffr_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [gffr_pkg::NUM_W-1:0] i_num,
    input  logic [gffr_pkg::DEN_W-1:0] i_den,
    output logic                       o_done,
    output logic [gffr_pkg::NUM_W-1:0] o_quot
);

    logic                        r_busy, n_busy;
    logic [gffr_pkg::STEP_W-1:0] r_cnt, n_cnt;
    logic [gffr_pkg::DEN_W-1:0]  r_rem, n_rem;
    logic [gffr_pkg::NUM_W-1:0]  r_q, n_q;
    logic [gffr_pkg::DEN_W-1:0]  r_den, n_den;
    logic                        r_done, n_done;
    logic [gffr_pkg::DEN_W:0]    rem_sh;

    always_comb begin
        n_busy = r_busy;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_q    = r_q;
        n_den  = r_den;
        n_done = 1'b0;
        rem_sh = {r_rem, r_q[gffr_pkg::NUM_W-1]};
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_rem  = '0;
            n_q    = i_num;
            n_den  = i_den;
        end else if (r_busy) begin
            if (rem_sh >= {1'b0, r_den}) begin
                n_rem = gffr_pkg::DEN_W'(rem_sh - {1'b0, r_den});
                n_q   = {r_q[gffr_pkg::NUM_W-2:0], 1'b1};
            end else begin
                n_rem = gffr_pkg::DEN_W'(rem_sh);
                n_q   = {r_q[gffr_pkg::NUM_W-2:0], 1'b0};
            end
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == gffr_pkg::STEP_W'(gffr_pkg::DIV_STEPS - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rem <= n_rem;
        r_q   <= n_q;
        r_den <= n_den;
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

// ===== hw/rtl/gffr_ctrl.sv =====
// sequencer of the allocator: divide, check, row union, column scan, mark
// depends on gffr_pkg for state, command and status types

module gffr_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_req_valid,
    output logic            o_req_ready,
    input  gffr_pkg::t_sts  i_sts,
    output gffr_pkg::t_cmd  o_cmd
);

    gffr_pkg::t_state r_state, n_state;

    always_comb begin
        n_state = r_state;
        case (r_state)
            gffr_pkg::ST_IDLE:    if (i_req_valid) n_state = gffr_pkg::ST_DIV_W;
            gffr_pkg::ST_DIV_W:   if (i_sts.div_done) n_state = gffr_pkg::ST_DIV_H;
            gffr_pkg::ST_DIV_H:   if (i_sts.div_done) n_state = gffr_pkg::ST_CHECK;
            gffr_pkg::ST_CHECK: begin
                n_state = i_sts.too_big ? gffr_pkg::ST_FINISH : gffr_pkg::ST_ACC_RD;
            end
            gffr_pkg::ST_ACC_RD:  n_state = gffr_pkg::ST_ACC_OR;
            gffr_pkg::ST_ACC_OR: begin
                n_state = i_sts.i_last ? gffr_pkg::ST_SCAN : gffr_pkg::ST_ACC_RD;
            end
            gffr_pkg::ST_SCAN: begin
                if (i_sts.scan_end) begin
                    n_state = i_sts.row_last ? gffr_pkg::ST_FINISH : gffr_pkg::ST_ACC_RD;
                end else if (i_sts.scan_hit) begin
                    n_state = gffr_pkg::ST_MARK_RD;
                end
            end
            gffr_pkg::ST_MARK_RD: n_state = gffr_pkg::ST_MARK_WR;
            gffr_pkg::ST_MARK_WR: begin
                n_state = i_sts.i_last ? gffr_pkg::ST_FINISH : gffr_pkg::ST_MARK_RD;
            end
            gffr_pkg::ST_FINISH:  if (i_sts.out_free) n_state = gffr_pkg::ST_IDLE;
            default:              n_state = gffr_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd       = '0;
        o_req_ready = 1'b0;
        case (r_state)
            gffr_pkg::ST_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    o_cmd.load      = 1'b1;
                    o_cmd.div_start = 1'b1;
                end
            end
            gffr_pkg::ST_DIV_W: begin
                if (i_sts.div_done) begin
                    o_cmd.take_nc   = 1'b1;
                    o_cmd.div_start = 1'b1;
                    o_cmd.div_sel_h = 1'b1;
                end
            end
            gffr_pkg::ST_DIV_H:   o_cmd.take_nr = i_sts.div_done;
            gffr_pkg::ST_CHECK:   o_cmd.row_start = !i_sts.too_big;
            gffr_pkg::ST_ACC_RD:  o_cmd.rd_en = 1'b1;
            gffr_pkg::ST_ACC_OR: begin
                o_cmd.acc        = 1'b1;
                o_cmd.scan_start = i_sts.i_last;
            end
            gffr_pkg::ST_SCAN: begin
                if (i_sts.scan_end) begin
                    o_cmd.next_row  = !i_sts.row_last;
                    o_cmd.row_start = !i_sts.row_last;
                end else begin
                    o_cmd.scan_step = 1'b1;
                    if (i_sts.scan_hit) begin
                        o_cmd.set_hit    = 1'b1;
                        o_cmd.mark_start = 1'b1;
                    end
                end
            end
            gffr_pkg::ST_MARK_RD: o_cmd.rd_en = 1'b1;
            gffr_pkg::ST_MARK_WR: o_cmd.mark_wr = 1'b1;
            gffr_pkg::ST_FINISH:  o_cmd.out_load = i_sts.out_free;
            default: begin
                o_cmd = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= gffr_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== hw/rtl/gffr_dp.sv =====
// datapath of the allocator: occupancy memory, divider, scan counters, result register
// depends on gffr_pkg, gffr_div and the result channel interface gffr_res_if

module gffr_dp #(
    parameter int MAX_COLS = 64,
    parameter int MAX_ROWS = 64
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  gffr_pkg::t_cfg              i_cfg,
    input  logic [gffr_pkg::IMG_W-1:0]  i_width,
    input  logic [gffr_pkg::IMG_W-1:0]  i_height,
    input  gffr_pkg::t_cmd              i_cmd,
    output gffr_pkg::t_sts              o_sts,
    gffr_res_if.source                  res
);

    localparam int CNW = $clog2(MAX_COLS + 1);
    localparam int RNW = $clog2(MAX_ROWS + 1);
    localparam int CIW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int RAW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int NW  = gffr_pkg::NUM_W;

    // occupancy memory, rows read as zero until first written
    logic [MAX_COLS-1:0] r_mem [MAX_ROWS];
    logic [MAX_ROWS-1:0] r_row_vld;
    logic [MAX_COLS-1:0] r_rd_data;
    logic                r_rd_vld;
    logic [MAX_COLS-1:0] rd_data;
    logic [RAW-1:0]      addr;

    logic [gffr_pkg::IMG_W-1:0]  r_w, r_h;
    logic [NW-1:0]               r_nc, r_nr;
    logic [RNW-1:0]              r_row, r_i;
    logic [CNW-1:0]              r_col, r_run, r_found;
    logic [MAX_COLS-1:0]         r_union;
    logic                        r_hit;

    logic [gffr_pkg::CELL_W-1:0] cw_eff, ch_eff;
    logic [CNW-1:0]              cols_eff;
    logic [RNW-1:0]              rows_eff;
    logic [NW-1:0]               div_num, div_quot, cells;
    logic [gffr_pkg::DEN_W-1:0]  div_den;
    logic                        div_done;
    logic [NW:0]                 run_inc;
    logic                        cur_bit;
    logic [CNW-1:0]              nc_c;
    logic [MAX_COLS-1:0]         mark_mask;
    logic [CNW+gffr_pkg::CELL_W-1:0] x_prod;
    logic [RNW+gffr_pkg::CELL_W-1:0] y_prod;

    logic                        r_ovalid;
    logic                        r_placed;
    logic [gffr_pkg::POS_W-1:0]  r_ocol, r_orow;
    logic [gffr_pkg::OFS_W-1:0]  r_ox, r_oy;

    // effective configuration
    assign cw_eff   = (i_cfg.cell_width_px == '0) ? gffr_pkg::CELL_W'(1) : i_cfg.cell_width_px;
    assign ch_eff   = (i_cfg.cell_height_px == '0) ? gffr_pkg::CELL_W'(1) : i_cfg.cell_height_px;
    assign cols_eff = (9'(i_cfg.grid_cols) > 9'(MAX_COLS)) ? CNW'(MAX_COLS)
                                                           : CNW'(i_cfg.grid_cols);
    assign rows_eff = (9'(i_cfg.grid_rows) > 9'(MAX_ROWS)) ? RNW'(MAX_ROWS)
                                                           : RNW'(i_cfg.grid_rows);

    // ceiling division shares one divider for width and height
    assign div_den = i_cmd.div_sel_h ? ch_eff : cw_eff;
    assign div_num = i_cmd.div_sel_h
                   ? NW'(NW'(r_h) + NW'(ch_eff) - NW'(1))
                   : NW'(NW'(i_cmd.load ? i_width : r_w) + NW'(cw_eff) - NW'(1));
    assign cells   = (div_quot == '0) ? NW'(1) : div_quot;

    gffr_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    assign addr    = RAW'(r_row + r_i);
    assign rd_data = r_rd_vld ? r_rd_data : '0;
    assign nc_c    = CNW'(r_nc);
    assign run_inc = (NW+1)'(r_run) + (NW+1)'(1);
    assign cur_bit = r_union[r_col[CIW-1:0]];
    assign mark_mask = (~({MAX_COLS{1'b1}} << nc_c)) << r_found;
    assign x_prod  = r_found * cw_eff;
    assign y_prod  = r_row * ch_eff;

    assign o_sts.div_done = div_done;
    assign o_sts.too_big  = (r_nc > NW'(cols_eff)) || (r_nr > NW'(rows_eff));
    assign o_sts.i_last   = ((NW+1)'(r_i) + (NW+1)'(1)) == {1'b0, r_nr};
    assign o_sts.scan_end = (r_col == cols_eff);
    assign o_sts.scan_hit = !cur_bit && (run_inc == {1'b0, r_nc});
    assign o_sts.row_last = ((NW+1)'(r_row) + (NW+1)'(1) + (NW+1)'(r_nr))
                          > (NW+1)'(rows_eff);
    assign o_sts.out_free = !r_ovalid || res.ready;

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_en) begin
            r_rd_data <= r_mem[addr];
            r_rd_vld  <= r_row_vld[addr];
        end
        if (i_cmd.mark_wr) begin
            r_mem[addr] <= rd_data | mark_mask;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_vld <= '0;
        end else if (i_cmd.mark_wr) begin
            r_row_vld[addr] <= 1'b1;
        end
    end

    // request registers and scan counters
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_w   <= i_width;
            r_h   <= i_height;
            r_row <= '0;
            r_hit <= 1'b0;
        end
        if (i_cmd.take_nc) r_nc <= cells;
        if (i_cmd.take_nr) r_nr <= cells;
        if (i_cmd.next_row) r_row <= r_row + 1'b1;
        if (i_cmd.row_start || i_cmd.mark_start) r_i <= '0;
        if (i_cmd.row_start) r_union <= '0;
        if (i_cmd.acc) begin
            r_union <= r_union | rd_data;
            r_i     <= r_i + 1'b1;
        end
        if (i_cmd.mark_wr) r_i <= r_i + 1'b1;
        if (i_cmd.scan_start) begin
            r_col <= '0;
            r_run <= '0;
        end
        if (i_cmd.scan_step) begin
            r_col <= r_col + 1'b1;
            r_run <= cur_bit ? '0 : CNW'(run_inc);
            if (o_sts.scan_hit) r_found <= CNW'(r_col + CNW'(1) - nc_c);
        end
        if (i_cmd.set_hit) r_hit <= 1'b1;
    end

    // result register, offsets saturate at the field limit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_ovalid <= 1'b1;
        end else if (res.ready) begin
            r_ovalid <= 1'b0;
        end
        if (i_cmd.out_load) begin
            r_placed <= r_hit;
            if (r_hit) begin
                r_ocol <= gffr_pkg::POS_W'(r_found);
                r_orow <= gffr_pkg::POS_W'(r_row);
                r_ox   <= (x_prod > (CNW+gffr_pkg::CELL_W)'(gffr_pkg::OFS_MAX))
                        ? gffr_pkg::OFS_MAX : gffr_pkg::OFS_W'(x_prod);
                r_oy   <= (y_prod > (RNW+gffr_pkg::CELL_W)'(gffr_pkg::OFS_MAX))
                        ? gffr_pkg::OFS_MAX : gffr_pkg::OFS_W'(y_prod);
            end else begin
                r_ocol <= '0;
                r_orow <= '0;
                r_ox   <= '0;
                r_oy   <= '0;
            end
        end
    end

    assign res.valid    = r_ovalid;
    assign res.placed   = r_placed;
    assign res.cell_col = r_ocol;
    assign res.cell_row = r_orow;
    assign res.x_offset = r_ox;
    assign res.y_offset = r_oy;

endmodule

// ===== tb/testbench.sv =====
// self-checking testbench of the grid first-fit rectangle allocator
// depends on gffr_pkg, gffr_if and grid_first_fit_rect_allocator

module testbench;

    // one expected result beat
    typedef struct packed {
        logic                       placed;
        logic [gffr_pkg::POS_W-1:0] cell_col;
        logic [gffr_pkg::POS_W-1:0] cell_row;
        logic [gffr_pkg::OFS_W-1:0] x_offset;
        logic [gffr_pkg::OFS_W-1:0] y_offset;
    } t_placement;

    localparam int GRID_MAX   = 64;
    localparam int IDLE_LIMIT = 100000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    gffr_req_if req_ch ();
    gffr_res_if res_ch ();

    grid_first_fit_rect_allocator dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_res   (res_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #2 i_clk = ~i_clk;

    // shadow of the configuration registers and the occupancy bitmap
    logic [gffr_pkg::CELL_W-1:0] cell_w_shadow = 11'd32;
    logic [gffr_pkg::CELL_W-1:0] cell_h_shadow = 11'd32;
    logic [gffr_pkg::GRID_W-1:0] cols_shadow   = 7'd64;
    logic [gffr_pkg::GRID_W-1:0] rows_shadow   = 7'd64;
    bit                          used_cell [GRID_MAX][GRID_MAX];

    t_placement pending_placements [$];
    int         error_count = 0;
    int         mismatch_count = 0;
    bit         calm = 1'b0;      // no idling in the last part of the run
    int         idle_cycles = 0;

    // size in pixels to whole cells, zero counts as one cell
    function automatic int cells_for(int px, int cell_px);
        int n;
        if (cell_px == 0) cell_px = 1;
        n = (px + cell_px - 1) / cell_px;
        return (n == 0) ? 1 : n;
    endfunction

    function automatic bit area_clear(int r, int c, int nr, int nc);
        for (int i = 0; i < nr; i++)
            for (int j = 0; j < nc; j++)
                if (used_cell[r + i][c + j]) return 1'b0;
        return 1'b1;
    endfunction

    function automatic logic [gffr_pkg::OFS_W-1:0] clip16(int v);
        return (v > 65535) ? gffr_pkg::OFS_MAX : v[gffr_pkg::OFS_W-1:0];
    endfunction

    // first fit in row-major order, marks the rectangle when found
    function automatic t_placement place_image(int w, int h);
        t_placement p;
        int cw, ch, cols, rows, nc, nr;
        p    = '0;
        cw   = (cell_w_shadow == 0) ? 1 : cell_w_shadow;
        ch   = (cell_h_shadow == 0) ? 1 : cell_h_shadow;
        cols = (cols_shadow > GRID_MAX) ? GRID_MAX : cols_shadow;
        rows = (rows_shadow > GRID_MAX) ? GRID_MAX : rows_shadow;
        nc   = cells_for(w, cw);
        nr   = cells_for(h, ch);
        if (nc > cols || nr > rows) return p;
        for (int r = 0; r + nr <= rows; r++) begin
            for (int c = 0; c + nc <= cols; c++) begin
                if (area_clear(r, c, nr, nc)) begin
                    for (int i = 0; i < nr; i++)
                        for (int j = 0; j < nc; j++)
                            used_cell[r + i][c + j] = 1'b1;
                    p.placed   = 1'b1;
                    p.cell_col = c[gffr_pkg::POS_W-1:0];
                    p.cell_row = r[gffr_pkg::POS_W-1:0];
                    p.x_offset = clip16(c * cw);
                    p.y_offset = clip16(r * ch);
                    return p;
                end
            end
        end
        return p;
    endfunction

    // one request beat, with an optional burst of idle cycles ahead of it
    task automatic send_request(int w, int h);
        if (!calm && $urandom_range(0, 7) == 0) begin
            @(negedge i_clk);
            req_ch.valid = 1'b0;
            repeat ($urandom_range(1, 18) - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        req_ch.valid        = 1'b1;
        req_ch.image_width  = w[gffr_pkg::IMG_W-1:0];
        req_ch.image_height = h[gffr_pkg::IMG_W-1:0];
        do @(posedge i_clk); while (!req_ch.ready);
        pending_placements.push_back(place_image(w, h));
    endtask

    task automatic drain();
        @(negedge i_clk);
        req_ch.valid = 1'b0;
        while (pending_placements.size() != 0) @(posedge i_clk);
        repeat (20) @(negedge i_clk);
    endtask

    // apb write: setup then access phase, only while idle
    task automatic write_reg(logic [1:0] idx, int value);
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = value;
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        case (idx)
            gffr_pkg::REG_CELL_WIDTH:  cell_w_shadow = value[gffr_pkg::CELL_W-1:0];
            gffr_pkg::REG_CELL_HEIGHT: cell_h_shadow = value[gffr_pkg::CELL_W-1:0];
            gffr_pkg::REG_GRID_COLS:   cols_shadow   = value[gffr_pkg::GRID_W-1:0];
            gffr_pkg::REG_GRID_ROWS:   rows_shadow   = value[gffr_pkg::GRID_W-1:0];
            default: begin
            end
        endcase
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic set_grid(int cw, int ch, int cols, int rows);
        drain();
        write_reg(gffr_pkg::REG_CELL_WIDTH, cw);
        write_reg(gffr_pkg::REG_CELL_HEIGHT, ch);
        write_reg(gffr_pkg::REG_GRID_COLS, cols);
        write_reg(gffr_pkg::REG_GRID_ROWS, rows);
    endtask

    // extremes of the fields and the special cases at the reset settings
    task automatic test_directed();
        send_request(1, 1);             // top-left cell
        send_request(0, 0);             // zero size counts as one cell
        send_request(8191, 8191);       // far larger than the grid
        send_request(2048, 32);         // exactly the full grid width
        send_request(33, 65);           // rounds up to two by three cells
        send_request(4096, 1);          // twice the grid width
        set_grid(0, 0, 127, 127);       // zero cell size, grid clamped to storage
        send_request(64, 1);
        send_request(1, 0);
        set_grid(2047, 2047, 64, 64);   // largest cell size; offsets stay below the field limit here
        send_request(2047, 2047);
        send_request(4094, 2047);
        send_request(1, 1);
        set_grid(32, 32, 0, 4);         // empty grid never fits
        send_request(1, 1);
        set_grid(32, 32, 4, 0);
        send_request(1, 1);
        set_grid(1024, 1024, 1, 1);     // single cell grid
        send_request(1024, 1024);
        send_request(1, 1);
    endtask

    // small random grids keep each scan short while the map fills up
    task automatic test_random_small(int phases, int per_phase);
        int cw, ch;
        for (int p = 0; p < phases; p++) begin
            cw = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2047) : $urandom_range(1, 64);
            ch = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2047) : $urandom_range(1, 64);
            set_grid(cw, ch, $urandom_range(0, 9) == 0 ? $urandom_range(0, 127)
                                                        : $urandom_range(1, 16),
                     $urandom_range(1, 12));
            for (int k = 0; k < per_phase; k++) begin
                if ($urandom_range(0, 9) == 0)
                    send_request($urandom_range(0, 8191), $urandom_range(0, 8191));
                else
                    send_request($urandom_range(0, 3 * (cw + 1)),
                                 $urandom_range(0, 3 * (ch + 1)));
            end
        end
    endtask

    // full size grid, small images: reaches the lower rows and the last column
    task automatic test_random_wide(int count);
        set_grid(1, 1, 64, 64);
        for (int k = 0; k < count; k++)
            send_request($urandom_range(1, 12), $urandom_range(1, 12));
    endtask

    // result side: random stall bursts, sampled on the rising edge
    initial begin
        int stall_left;
        stall_left = 0;
        res_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (stall_left > 0) begin
                stall_left--;
                res_ch.ready = 1'b0;
            end else if (!calm && $urandom_range(0, 11) == 0) begin
                stall_left = $urandom_range(1, 18) - 1;
                res_ch.ready = 1'b0;
            end else begin
                res_ch.ready = 1'b1;
            end
        end
    end

    // compare each result beat with the oldest expectation
    always @(posedge i_clk) begin
        t_placement want;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            if (pending_placements.size() == 0) begin
                error_count++;
                if (mismatch_count++ < 10) $display("unexpected result beat");
            end else begin
                want = pending_placements.pop_front();
                if (res_ch.placed !== want.placed || res_ch.cell_col !== want.cell_col ||
                    res_ch.cell_row !== want.cell_row || res_ch.x_offset !== want.x_offset ||
                    res_ch.y_offset !== want.y_offset) begin
                    error_count++;
                    if (mismatch_count++ < 10)
                        $display("mismatch: exp %0d %0d %0d %0d %0d got %0d %0d %0d %0d %0d",
                                 want.placed, want.cell_col, want.cell_row, want.x_offset,
                                 want.y_offset, res_ch.placed, res_ch.cell_col,
                                 res_ch.cell_row, res_ch.x_offset, res_ch.y_offset);
                end
            end
        end
    end

    // watchdog on cycles with no beat on any port
    always @(posedge i_clk) begin
        if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready) || psel)
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end else
            idle_cycles <= idle_cycles + 1;
    end

    initial begin
        req_ch.valid        = 1'b0;
        req_ch.image_width  = '0;
        req_ch.image_height = '0;
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;
        test_directed();
        test_random_small(28, 60);
        test_random_wide(40);
        calm = 1'b1;
        test_random_small(4, 60);
        drain();
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/gffr_pkg.sv
hw/rtl/gffr_if.sv
hw/rtl/gffr_div.sv
hw/rtl/gffr_ctrl.sv
hw/rtl/gffr_dp.sv
hw/rtl/grid_first_fit_rect_allocator.sv
tb/testbench.sv
